// ----- hdl/jls_pkg.sv -----
// Jacobi linear solver: shared types, codes and sizes.
// Used by every module of the solver; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package jls_pkg;

	localparam int ORDER    = 8;
	localparam int IDX_W    = $clog2(ORDER);
	localparam int ADDR_W   = 2 * IDX_W;
	localparam int DATA_W   = 32;
	localparam int ITER_W   = 16;
	localparam int ACC_W    = 56;
	localparam int DVD_W    = 63;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);

	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_B = 2'd1;
	localparam logic [1:0] CMD_START  = 2'd2;

	localparam logic REG_MAX_ITER = 1'b0;
	localparam logic REG_TOL      = 1'b1;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]        index;
		logic signed [DATA_W-1:0] solution;
		logic [ITER_W-1:0]       iterations;
		logic [DATA_W-1:0]       first_step_sq;
		logic [DATA_W-1:0]       residual_sq;
		logic                    zero_diagonal;
		logic                    last;
	} rsp_t;

	typedef enum logic [1:0] {
		K_MAC_PREV,
		K_MAC_CUR,
		K_SQ_STEP,
		K_SQ_RES
	} kind_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SW_INIT,
		S_ROW_INIT,
		S_MAC_ISSUE,
		S_MAC_DRAIN,
		S_DIV_START,
		S_DIV_WAIT,
		S_STEP_INIT,
		S_STEP_ISSUE,
		S_STEP_DRAIN,
		S_CHECK,
		S_RES_INIT,
		S_RES_ROW,
		S_RES_ISSUE,
		S_RES_DRAIN,
		S_RES_SQ,
		S_RES_SQ_DRAIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic              load;
		logic              clr_run;
		logic              sweep_begin;
		logic              acc_clr;
		logic              issue;
		kind_t             kind;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              div_start;
		logic              cur_write;
		logic              record;
		logic [ITER_W-1:0] kcnt;
		logic              out_load;
		logic              out_last;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic div_done;
		logic below_tol;
		logic zdiag;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ----- hdl/jls_div.sv -----
// Jacobi linear solver: unsigned restoring divider, one quotient bit a cycle.
// Depends on jls_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module jls_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [jls_pkg::DVD_W-1:0]   dividend,
	input  wire logic [jls_pkg::DATA_W-1:0]  divisor,
	output logic      [jls_pkg::DVD_W-1:0]   quotient,
	output logic                             done
);

	logic [jls_pkg::DATA_W-1:0]    rem_q;
	logic [jls_pkg::DVD_W-1:0]     quo_q;
	logic [jls_pkg::DATA_W-1:0]    dvs_q;
	logic [jls_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [jls_pkg::DATA_W:0]      shifted;
	logic [jls_pkg::DATA_W:0]      diff;
	logic                          ge;

	always_comb begin
		shifted = {rem_q, quo_q[jls_pkg::DVD_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= jls_pkg::DIV_CNT_W'(jls_pkg::DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == jls_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[jls_pkg::DATA_W-1:0] : shifted[jls_pkg::DATA_W-1:0];
			quo_q <= {quo_q[jls_pkg::DVD_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// ----- hdl/jls_datapath.sv -----
// Jacobi linear solver datapath: matrix memory, vectors, shared multiplier
// pipeline, accumulators, divider and result register. Depends on jls_pkg, jls_div.
`timescale 1ns / 1ps
`default_nettype none

module jls_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire jls_pkg::req_t              req,
	input  wire logic [jls_pkg::DATA_W-1:0] tolerance_sq,
	input  wire jls_pkg::cmd_t              cmd,
	output jls_pkg::status_t                status,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output jls_pkg::rsp_t                   rsp
);

	localparam int AW = jls_pkg::ACC_W;
	localparam int DW = jls_pkg::DATA_W;
	localparam int PW = 2 * (DW + 1);

	function automatic logic [DW-1:0] mag_clamp(input logic signed [AW-1:0] v);
		logic [AW-1:0] m;
		m = v[AW-1] ? AW'(-v) : AW'(v);
		return (m > AW'({DW{1'b1}})) ? {DW{1'b1}} : m[DW-1:0];
	endfunction

	logic signed [DW-1:0] matrix_mem [0:jls_pkg::ORDER*jls_pkg::ORDER-1];
	logic signed [DW-1:0] rhs_q  [0:jls_pkg::ORDER-1];
	logic signed [DW-1:0] cur_q  [0:jls_pkg::ORDER-1];
	logic signed [DW-1:0] prev_q [0:jls_pkg::ORDER-1];
	logic [jls_pkg::ORDER-1:0] dz_q;

	logic signed [DW-1:0] rd_s1;
	logic signed [DW-1:0] x_s1;
	logic [DW-1:0]        sqm_s1;
	jls_pkg::kind_t       kind_s1;
	logic                 v_s1, incl_s1, diag_s1;
	logic signed [PW-1:0] prod_s2;
	logic                 v_s2, incl_s2, dest_s2;

	logic signed [AW-1:0] acc_q, nacc_q;
	logic signed [DW-1:0] diag_q;
	logic                 neg_q;
	logic [DW-1:0]        first_q;
	logic [jls_pkg::ITER_W-1:0] conv_q;

	logic signed [AW-1:0] step_d, res_d, term;
	logic signed [DW:0]   opa, opb;
	logic                 sq_s1;
	logic signed [AW:0]   num, num_c;
	logic [jls_pkg::DVD_W-1:0] dividend, quotient;
	logic [DW-1:0]        divisor, sol;
	logic                 div_done;
	logic                 is_diag;
	logic [DW-1:0]        acc_sat, nacc_sat;
	logic [AW:0]          lim;

	always_ff @(posedge clk) begin
		if (cmd.load && req.cmd == jls_pkg::CMD_LOAD_A)
			matrix_mem[{req.row, req.col}] <= req.value;
		rd_s1 <= matrix_mem[{cmd.row, cmd.col}];
	end

	always_ff @(posedge clk) begin
		if (cmd.load && req.cmd == jls_pkg::CMD_LOAD_B)
			rhs_q[req.row] <= req.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= '0;
		end else if (cmd.load && req.cmd == jls_pkg::CMD_LOAD_A && req.row == req.col) begin
			dz_q[req.row] <= (req.value == '0);
		end
	end

	always_comb begin
		is_diag = (cmd.kind == jls_pkg::K_MAC_PREV) && (cmd.col == cmd.row);
		step_d  = AW'(cur_q[cmd.col]) - AW'(prev_q[cmd.col]);
		res_d   = acc_q - AW'(rhs_q[cmd.row]);
		sq_s1   = (kind_s1 == jls_pkg::K_SQ_STEP) || (kind_s1 == jls_pkg::K_SQ_RES);
		opa     = sq_s1 ? $signed({1'b0, sqm_s1}) : (DW+1)'(rd_s1);
		opb     = sq_s1 ? $signed({1'b0, sqm_s1}) : (DW+1)'(x_s1);
		term    = AW'(prod_s2 >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= cmd.kind;
		incl_s1 <= !is_diag;
		diag_s1 <= is_diag;
		x_s1    <= (cmd.kind == jls_pkg::K_MAC_CUR) ? cur_q[cmd.col] : prev_q[cmd.col];
		sqm_s1  <= (cmd.kind == jls_pkg::K_SQ_STEP) ? mag_clamp(step_d) : mag_clamp(res_d);
		prod_s2 <= opa * opb;
		incl_s2 <= incl_s1;
		dest_s2 <= (kind_s1 == jls_pkg::K_SQ_RES);
		if (v_s1 && diag_s1)
			diag_q <= rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			nacc_q <= '0;
		end else begin
			if (cmd.acc_clr)
				acc_q <= '0;
			else if (v_s2 && incl_s2 && !dest_s2)
				acc_q <= acc_q + term;
			if (cmd.clr_run)
				nacc_q <= '0;
			else if (v_s2 && dest_s2)
				nacc_q <= nacc_q + term;
		end
	end

	always_comb begin
		lim      = (AW+1)'(64'sd1 <<< 46);
		num      = (AW+1)'(rhs_q[cmd.row]) - (AW+1)'(acc_q);
		if (num > $signed(lim))
			num_c = $signed(lim);
		else if (num < -$signed(lim))
			num_c = -$signed(lim);
		else
			num_c = num;
		dividend = {(num_c[AW] ? 47'(-num_c) : 47'(num_c)), 16'b0};
		divisor  = diag_q[DW-1] ? (~diag_q + 1'b1) : diag_q;
		if (neg_q)
			sol = (quotient > jls_pkg::DVD_W'(64'h8000_0000)) ? 32'h8000_0000
				: (~quotient[DW-1:0] + 1'b1);
		else
			sol = (quotient > jls_pkg::DVD_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF
				: quotient[DW-1:0];
		acc_sat  = ($unsigned(acc_q) > AW'({DW{1'b1}})) ? {DW{1'b1}} : acc_q[DW-1:0];
		nacc_sat = ($unsigned(nacc_q) > AW'({DW{1'b1}})) ? {DW{1'b1}} : nacc_q[DW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start)
			neg_q <= num_c[AW] ^ diag_q[DW-1];
	end

	jls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < jls_pkg::ORDER; i++) begin
				cur_q[i]  <= '0;
				prev_q[i] <= '0;
			end
			first_q <= '0;
			conv_q  <= '0;
		end else begin
			if (cmd.clr_run) begin
				for (int i = 0; i < jls_pkg::ORDER; i++) begin
					cur_q[i]  <= '0;
					prev_q[i] <= '0;
				end
				first_q <= '0;
				conv_q  <= '0;
			end else begin
				if (cmd.sweep_begin)
					for (int i = 0; i < jls_pkg::ORDER; i++)
						prev_q[i] <= cur_q[i];
				if (cmd.cur_write)
					cur_q[cmd.row] <= $signed(sol);
				if (cmd.record) begin
					if (cmd.kcnt == '0)
						first_q <= acc_sat;
					if (status.below_tol)
						conv_q <= cmd.kcnt + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid <= 1'b0;
		else if (cmd.out_load)
			rsp_valid <= 1'b1;
		else if (!rsp_stall)
			rsp_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp.index         <= cmd.col;
			rsp.solution      <= cur_q[cmd.col];
			rsp.iterations    <= cmd.out_last ? conv_q : '0;
			rsp.first_step_sq <= cmd.out_last ? first_q : '0;
			rsp.residual_sq   <= cmd.out_last ? nacc_sat : '0;
			rsp.zero_diagonal <= cmd.out_last && (|dz_q);
			rsp.last          <= cmd.out_last;
		end
	end

	always_comb begin
		status.busy      = v_s1 || v_s2;
		status.div_done  = div_done;
		status.below_tol = $unsigned(acc_q) < AW'(tolerance_sq);
		status.zdiag     = |dz_q;
		status.out_free  = !rsp_valid || !rsp_stall;
	end

endmodule

`default_nettype wire

// ----- hdl/jls_ctrl.sv -----
// Jacobi linear solver controller: sequences sweeps, rows, residual and output.
// Depends on jls_pkg; drives jls_datapath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module jls_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire jls_pkg::req_t               req,
	input  wire logic [jls_pkg::ITER_W-1:0]  max_iterations,
	input  wire jls_pkg::status_t            status,
	output jls_pkg::cmd_t                    cmd
);

	localparam logic [jls_pkg::IDX_W-1:0] LAST_IDX = jls_pkg::IDX_W'(jls_pkg::ORDER - 1);

	jls_pkg::state_t state_q, state_d;
	logic [jls_pkg::IDX_W-1:0]  row_q, row_d, col_q, col_d;
	logic [jls_pkg::ITER_W-1:0] kcnt_q, kcnt_d;
	logic                       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jls_pkg::S_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			kcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			kcnt_q  <= kcnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		row_d   = row_q;
		col_d   = col_q;
		kcnt_d  = kcnt_q;
		req_stall = (state_q != jls_pkg::S_IDLE);
		accept    = req_valid && !req_stall;

		cmd = '0;
		cmd.kind = jls_pkg::K_MAC_PREV;
		cmd.row  = row_q;
		cmd.col  = col_q;
		cmd.kcnt = kcnt_q;

		unique case (state_q)
			jls_pkg::S_IDLE: begin
				cmd.load = accept;
				if (accept && req.cmd == jls_pkg::CMD_START) begin
					cmd.clr_run = 1'b1;
					kcnt_d = '0;
					row_d  = '0;
					col_d  = '0;
					if (status.zdiag)
						state_d = jls_pkg::S_OUT;
					else if (max_iterations == '0)
						state_d = jls_pkg::S_RES_INIT;
					else
						state_d = jls_pkg::S_SW_INIT;
				end
			end
			jls_pkg::S_SW_INIT: begin
				cmd.sweep_begin = 1'b1;
				row_d   = '0;
				state_d = jls_pkg::S_ROW_INIT;
			end
			jls_pkg::S_ROW_INIT: begin
				cmd.acc_clr = 1'b1;
				col_d   = '0;
				state_d = jls_pkg::S_MAC_ISSUE;
			end
			jls_pkg::S_MAC_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.kind  = jls_pkg::K_MAC_PREV;
				col_d = col_q + 1'b1;
				if (col_q == LAST_IDX)
					state_d = jls_pkg::S_MAC_DRAIN;
			end
			jls_pkg::S_MAC_DRAIN: begin
				if (!status.busy)
					state_d = jls_pkg::S_DIV_START;
			end
			jls_pkg::S_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d = jls_pkg::S_DIV_WAIT;
			end
			jls_pkg::S_DIV_WAIT: begin
				if (status.div_done) begin
					cmd.cur_write = 1'b1;
					if (row_q == LAST_IDX) begin
						state_d = jls_pkg::S_STEP_INIT;
					end else begin
						row_d   = row_q + 1'b1;
						state_d = jls_pkg::S_ROW_INIT;
					end
				end
			end
			jls_pkg::S_STEP_INIT: begin
				cmd.acc_clr = 1'b1;
				col_d   = '0;
				state_d = jls_pkg::S_STEP_ISSUE;
			end
			jls_pkg::S_STEP_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.kind  = jls_pkg::K_SQ_STEP;
				col_d = col_q + 1'b1;
				if (col_q == LAST_IDX)
					state_d = jls_pkg::S_STEP_DRAIN;
			end
			jls_pkg::S_STEP_DRAIN: begin
				if (!status.busy)
					state_d = jls_pkg::S_CHECK;
			end
			jls_pkg::S_CHECK: begin
				cmd.record = 1'b1;
				kcnt_d = kcnt_q + 1'b1;
				if (status.below_tol ||
				    ({1'b0, kcnt_q} + 1'b1) == {1'b0, max_iterations})
					state_d = jls_pkg::S_RES_INIT;
				else
					state_d = jls_pkg::S_SW_INIT;
			end
			jls_pkg::S_RES_INIT: begin
				row_d   = '0;
				state_d = jls_pkg::S_RES_ROW;
			end
			jls_pkg::S_RES_ROW: begin
				cmd.acc_clr = 1'b1;
				col_d   = '0;
				state_d = jls_pkg::S_RES_ISSUE;
			end
			jls_pkg::S_RES_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.kind  = jls_pkg::K_MAC_CUR;
				col_d = col_q + 1'b1;
				if (col_q == LAST_IDX)
					state_d = jls_pkg::S_RES_DRAIN;
			end
			jls_pkg::S_RES_DRAIN: begin
				if (!status.busy)
					state_d = jls_pkg::S_RES_SQ;
			end
			jls_pkg::S_RES_SQ: begin
				cmd.issue = 1'b1;
				cmd.kind  = jls_pkg::K_SQ_RES;
				state_d = jls_pkg::S_RES_SQ_DRAIN;
			end
			jls_pkg::S_RES_SQ_DRAIN: begin
				if (!status.busy) begin
					if (row_q == LAST_IDX) begin
						col_d   = '0;
						state_d = jls_pkg::S_OUT;
					end else begin
						row_d   = row_q + 1'b1;
						state_d = jls_pkg::S_RES_ROW;
					end
				end
			end
			jls_pkg::S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = (col_q == LAST_IDX);
					col_d = col_q + 1'b1;
					if (col_q == LAST_IDX)
						state_d = jls_pkg::S_IDLE;
				end
			end
			default: state_d = jls_pkg::S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/jacobi_linear_solver.sv -----
// Jacobi linear solver top level: configuration registers, controller, datapath.
// Depends on jls_pkg, jls_ctrl, jls_datapath.
//
//   channel | handshake            | payload
//   req     | req_valid/req_stall  | jls_pkg::req_t (cmd, row, col, value)
//   rsp     | rsp_valid/rsp_stall  | jls_pkg::rsp_t (index .. last)
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A start request runs sweeps, each dominated by the radix-2 divider,
// then a residual pass and the results, one per unknown.
// arst_n clears control state, the solution vectors and the configuration registers.
// Requests stall while a solve runs; results hold while rsp_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_linear_solver (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire jls_pkg::req_t              req,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output jls_pkg::rsp_t                   rsp,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic                       cfg_index,
	input  wire logic [jls_pkg::DATA_W-1:0] cfg_data
);

	logic [jls_pkg::ITER_W-1:0] max_iter_q;
	logic [jls_pkg::DATA_W-1:0] tol_q;
	jls_pkg::cmd_t              cmd;
	jls_pkg::status_t           status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= jls_pkg::ITER_W'(1000);
			tol_q      <= jls_pkg::DATA_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jls_pkg::REG_MAX_ITER: max_iter_q <= cfg_data[jls_pkg::ITER_W-1:0];
				jls_pkg::REG_TOL:      tol_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	jls_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.max_iterations (max_iter_q),
		.status         (status),
		.cmd            (cmd)
	);

	jls_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.tolerance_sq (tol_q),
		.cmd          (cmd),
		.status       (status),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp)
	);

endmodule

`default_nettype wire
